>>> rtl/assert_macros.svh
// assertion macros used by the core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> rtl/lbmc_pkg.sv
// types and constants for the laser bias and modulation control core
`default_nettype none

package lbmc_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_FEATURE_ENABLES = 3'd0;
    localparam logic [2:0] REG_POWER_TARGET    = 3'd1;
    localparam logic [2:0] REG_BIAS_LIMIT_MA   = 3'd2;
    localparam logic [2:0] REG_BIAS_PRESET     = 3'd3;
    localparam logic [2:0] REG_MOD_PRESET      = 3'd4;
    localparam logic [2:0] REG_MOD_COEFF_LOW   = 3'd5;
    localparam logic [2:0] REG_MOD_COEFF_HIGH  = 3'd6;

    // feature enable bits
    localparam int FE_BIAS_LIMIT = 0;
    localparam int FE_POWER_CTRL = 1;
    localparam int FE_MOD_TABLE  = 2;

    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 24;

    // 500 counts of 2 uA per mA
    localparam logic [16:0] BIAS_LIMIT_SCALE = 17'd500;
    localparam logic [22:0] POWER_SCALE      = 23'd100;
    localparam logic [22:0] BAND_HIGH_PCT    = 23'd103;
    localparam logic [22:0] BAND_LOW_PCT     = 23'd97;

    // 255.0 in Q16
    localparam logic signed [33:0] MOD_SAT_Q16 = 34'sd16711680;
    localparam logic [7:0]         MOD_MAX     = 8'd255;

    typedef struct packed {
        logic signed [15:0] chip_temperature;
        logic [15:0]        power_reading;
        logic [15:0]        bias_reading;
        logic               laser_fault;
        logic               tx_disable_pin;
        logic               soft_tx_disable;
    } in_beat_t;

    typedef struct packed {
        logic       refresh_request;
        logic       mod_write;
        logic [7:0] mod_code;
        logic       bias_write;
        logic [6:0] bias_code;
        logic       transmitter_on;
        logic       laser_disable;
    } out_beat_t;

endpackage

`default_nettype wire

>>> rtl/laser_bias_mod_control_core.sv
// top level of the laser bias and modulation control core
//
// usage
//  one input beat per control tick on the s_ channel: disable pins, fault,
//  bias and power readings, chip temperature, and the coefficient range in
//  s_tuser. each beat gives exactly one result beat on the m_ channel with
//  the laser enables, bias and modulation dac codes and their write strobes.
//  the config port (cfg_we, cfg_index, cfg_wdata) writes one register per
//  cycle. the user must write it only while idle; the core does not enforce it.
// pipeline
//  an input beat passes through an input register, then the control step (one
//  16x16 multiply plus compares) into the result register. one beat per cycle
//  sustained while m_tready stays high.
// reset
//  aresetn low clears both valid flags, the config registers and the dac codes;
//  the first beat after reset loads both presets and raises all write strobes.
// backpressure
//  a stalled result holds; one more beat is taken into the input register,
//  then s_tready drops until the result is taken. no beat is dropped.
`default_nettype none
`include "assert_macros.svh"

module laser_bias_mod_control_core
    import lbmc_pkg::*;
#(
    parameter int BIAS_DAC_MAX = 127
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    // config write port
    input  wire                   cfg_we,
    input  wire [2:0]             cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_wdata,
    // input channel
    input  wire                   s_tvalid,
    output logic                  s_tready,
    // soft_tx_disable, tx_disable_pin, laser_fault, bias_reading[15:0],
    // power_reading[15:0], chip_temperature[15:0], zero pad
    input  wire [S_DATA_W-1:0]    s_tdata,
    // high_temp_range
    input  wire                   s_tuser,
    // result channel
    output logic                  m_tvalid,
    input  wire                   m_tready,
    // laser_disable, transmitter_on, bias_code[6:0], bias_write,
    // mod_code[7:0], mod_write, refresh_request, zero pad
    output logic [M_DATA_W-1:0]   m_tdata
);

    // highest code power control may step up to
    localparam logic [6:0] BIAS_TOP = (BIAS_DAC_MAX > 127) ? 7'd127 : 7'(BIAS_DAC_MAX);

    // configuration registers
    logic [2:0]  feature_enables_reg;
    logic [15:0] power_target_reg;
    logic [7:0]  bias_limit_ma_reg;
    logic [6:0]  bias_preset_reg;
    logic [7:0]  mod_preset_reg;
    logic [31:0] mod_coeff_low_reg;
    logic [31:0] mod_coeff_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            feature_enables_reg <= '0;
            power_target_reg    <= '0;
            bias_limit_ma_reg   <= '0;
            bias_preset_reg     <= '0;
            mod_preset_reg      <= '0;
            mod_coeff_low_reg   <= '0;
            mod_coeff_high_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FEATURE_ENABLES: feature_enables_reg <= cfg_wdata[2:0];
                REG_POWER_TARGET:    power_target_reg    <= cfg_wdata[15:0];
                REG_BIAS_LIMIT_MA:   bias_limit_ma_reg   <= cfg_wdata[7:0];
                REG_BIAS_PRESET:     bias_preset_reg     <= cfg_wdata[6:0];
                REG_MOD_PRESET:      mod_preset_reg      <= cfg_wdata[7:0];
                REG_MOD_COEFF_LOW:   mod_coeff_low_reg   <= cfg_wdata;
                REG_MOD_COEFF_HIGH:  mod_coeff_high_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline handshake
    logic      in_valid_reg;
    in_beat_t  in_beat_reg;
    logic      in_hirange_reg;
    logic      out_valid_reg;
    out_beat_t out_beat_reg;
    logic      advance;

    // step moves from input register to result register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_beat_reg    <= in_beat_t'(s_tdata[50:0]);
            in_hirange_reg <= s_tuser;
        end
    end

    // control state
    logic       first_reg;
    logic [6:0] bias_dac_reg;
    logic [7:0] mod_dac_reg;

    logic       first_next;
    logic [6:0] bias_dac_next;
    logic [7:0] mod_dac_next;
    out_beat_t  out_beat_next;

    // per-step intermediates
    logic        laser_on;
    logic        tx_on;
    logic [6:0]  bias_start;
    logic [7:0]  mod_start;
    logic [16:0] bias_lim;
    logic        lim_en;
    logic        over_lim;
    logic        under_lim;
    logic [22:0] power_scaled;
    logic        above_band;
    logic        below_band;
    logic [31:0] coeff;
    logic signed [15:0] slope;
    logic signed [15:0] offs;
    logic signed [31:0] prod;
    logic signed [33:0] mod_v;
    logic [7:0]  mod_calc;
    logic        refresh;

    always_comb begin
        // first step after reset works from the presets
        bias_start = first_reg ? bias_preset_reg : bias_dac_reg;
        mod_start  = first_reg ? mod_preset_reg : mod_dac_reg;

        laser_on = !in_beat_reg.soft_tx_disable && !in_beat_reg.tx_disable_pin;
        tx_on    = laser_on && !in_beat_reg.tx_disable_pin && !in_beat_reg.laser_fault;

        lim_en    = feature_enables_reg[FE_BIAS_LIMIT];
        bias_lim  = {9'd0, bias_limit_ma_reg} * BIAS_LIMIT_SCALE;
        over_lim  = {1'b0, in_beat_reg.bias_reading} > bias_lim;
        under_lim = {1'b0, in_beat_reg.bias_reading} < bias_lim;

        // band edges, 97 and 103 percent of target
        power_scaled = {7'd0, in_beat_reg.power_reading} * POWER_SCALE;
        above_band   = power_scaled > ({7'd0, power_target_reg} * BAND_HIGH_PCT);
        below_band   = power_scaled < ({7'd0, power_target_reg} * BAND_LOW_PCT);

        // temperature line: Q8.8 temperature times Q8.8 slope plus offset in Q16
        coeff = in_hirange_reg ? mod_coeff_high_reg : mod_coeff_low_reg;
        slope = $signed(coeff[31:16]);
        offs  = $signed(coeff[15:0]);
        prod  = in_beat_reg.chip_temperature * slope;
        mod_v = {{2{prod[31]}}, prod} + {{2{offs[15]}}, offs, 16'd0};
        if (mod_v >= MOD_SAT_Q16) begin
            mod_calc = MOD_MAX;
        end else if (mod_v <= 34'sd0) begin
            mod_calc = 8'd0;
        end else begin
            mod_calc = mod_v[23:16];
        end

        bias_dac_next = bias_start;
        mod_dac_next  = mod_start;
        refresh       = first_reg;

        if (tx_on) begin
            if (lim_en && over_lim) begin
                // current limit wins over power control
                if (bias_start != 7'd0) begin
                    bias_dac_next = bias_start - 7'd1;
                end
                refresh = 1'b1;
            end else if (feature_enables_reg[FE_POWER_CTRL]) begin
                if (above_band && bias_start != 7'd0) begin
                    bias_dac_next = bias_start - 7'd1;
                    refresh       = 1'b1;
                end else if (below_band && bias_start < BIAS_TOP
                             && (!lim_en || under_lim)) begin
                    bias_dac_next = bias_start + 7'd1;
                    refresh       = 1'b1;
                end
            end else begin
                bias_dac_next = bias_preset_reg;
            end

            if (feature_enables_reg[FE_MOD_TABLE]) begin
                mod_dac_next = mod_calc;
            end else begin
                mod_dac_next = mod_preset_reg;
            end
        end

        first_next = first_reg && !advance;

        out_beat_next.laser_disable   = !laser_on;
        out_beat_next.transmitter_on  = tx_on;
        out_beat_next.bias_code       = bias_dac_next;
        out_beat_next.bias_write      = first_reg || (bias_dac_next != bias_start);
        out_beat_next.mod_code        = mod_dac_next;
        out_beat_next.mod_write       = first_reg || (mod_dac_next != mod_start);
        out_beat_next.refresh_request = refresh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg     <= 1'b1;
            bias_dac_reg  <= '0;
            mod_dac_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            first_reg <= first_next;
            if (advance) begin
                bias_dac_reg  <= bias_dac_next;
                mod_dac_reg   <= mod_dac_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_beat_reg <= out_beat_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_beat_reg};

    // checks

    // control state only moves when a step lands in the result register
    `ASSERT_NEXT(a_state_hold_on_stall, aclk, aresetn,
        out_valid_reg && !m_tready, $stable(bias_dac_reg) && $stable(mod_dac_reg))

    // preset load happens exactly once, on a real step
    `ASSERT_IMP(a_first_clears_on_step, aclk, aresetn,
        $fell(first_reg), $past(advance))

    // inactive transmitter holds the codes after the first step
    `ASSERT_IMP(a_idle_tx_no_write, aclk, aresetn,
        advance && !first_reg && !tx_on,
        !out_beat_next.bias_write && !out_beat_next.mod_write)

    // a full input register with a blocked result stage refuses new beats
    `ASSERT_IMP(a_no_accept_when_full, aclk, aresetn,
        in_valid_reg && out_valid_reg && !m_tready, !s_tready)

endmodule

`default_nettype wire

>>> test/tb_laser_bias_mod_control_core.sv
// self-checking testbench for the laser bias and modulation control core
`default_nettype none

module tb_laser_bias_mod_control_core
    import lbmc_pkg::*;
();

    // highest bias code the control loop may step to
    localparam int BIAS_TOP   = 127;
    localparam int RUN_PHASES = 12;
    localparam int PHASE_BEATS = 150;

    typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;

    // one line of stimulus: a register write or an input beat
    typedef struct {
        row_kind_t             kind;
        logic [2:0]            reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        in_beat_t              beat;
        logic                  hi_range;
        bit                    typed;
        out_beat_t             typed_result;
    } stim_row_t;

    // clock, reset and dut ports; the dut inputs are driven from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [2:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    wire                   s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    wire                   m_tvalid;
    logic                  m_tready  = 1'b0;
    wire  [M_DATA_W-1:0]   m_tdata;

    // register copies kept by the predictor
    logic [2:0]  fe_q          = '0;
    logic [15:0] target_q      = '0;
    logic [7:0]  limit_q       = '0;
    logic [6:0]  bias_preset_q = '0;
    logic [7:0]  mod_preset_q  = '0;
    logic [31:0] coeff_low_q   = '0;
    logic [31:0] coeff_high_q  = '0;

    // control state kept by the predictor
    bit          first_tick = 1'b1;
    logic [6:0]  bias_dac_q = '0;
    logic [7:0]  mod_dac_q  = '0;

    out_beat_t   pending_results[$];
    int          mismatches     = 0;
    int          ready_wait     = 0;
    bit          calm           = 1'b0;
    bit          s_valid_held   = 1'b0;

    laser_bias_mod_control_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // hard stop in case a beat never shows up
    initial begin
        #2000000;
        $display("laser_bias_mod_control_core: mismatch");
        $finish;
    end

    // modulation line: q8.8 slope times q8.8 temperature plus offset, clipped to 0..255
    function automatic logic [7:0] mod_from_curve(logic [31:0] coeff,
                                                  logic signed [15:0] temp);
        longint slope;
        longint offset;
        longint t;
        longint v;
        slope  = $signed(coeff[31:16]);
        offset = $signed(coeff[15:0]);
        t      = temp;
        v      = t * slope + offset * 65536;
        if (v >= longint'(MOD_SAT_Q16))
            return MOD_MAX;
        if (v <= 0)
            return 8'd0;
        return v[23:16];
    endfunction

    // one control tick: advances the predictor state, returns the result beat
    function automatic out_beat_t step_laser_loop(in_beat_t b, logic hi);
        out_beat_t   r;
        logic [6:0]  prev_bias;
        logic [7:0]  prev_mod;
        bit          bwr;
        bit          mwr;
        bit          refresh;
        bit          laser_on;
        bit          tx_on;
        bit          lim_en;
        int unsigned lim;
        bwr     = 1'b0;
        mwr     = 1'b0;
        refresh = 1'b0;
        // first tick after reset loads both presets and strobes everything
        if (first_tick) begin
            bias_dac_q = bias_preset_q;
            mod_dac_q  = mod_preset_q;
            bwr        = 1'b1;
            mwr        = 1'b1;
            refresh    = 1'b1;
            first_tick = 1'b0;
        end
        prev_bias = bias_dac_q;
        prev_mod  = mod_dac_q;
        laser_on  = !b.soft_tx_disable && !b.tx_disable_pin;
        tx_on     = laser_on && !b.laser_fault;
        if (tx_on) begin
            lim_en = fe_q[FE_BIAS_LIMIT];
            lim    = 500 * limit_q;
            if (lim_en && b.bias_reading > lim) begin
                // over the current limit: step down, saturating at zero
                if (bias_dac_q != 0)
                    bias_dac_q = bias_dac_q - 7'd1;
                refresh = 1'b1;
            end else if (fe_q[FE_POWER_CTRL]) begin
                if (100 * b.power_reading > 103 * target_q && bias_dac_q != 0) begin
                    bias_dac_q = bias_dac_q - 7'd1;
                    refresh    = 1'b1;
                end
                if (100 * b.power_reading < 97 * target_q && bias_dac_q < BIAS_TOP) begin
                    if (!lim_en || b.bias_reading < lim) begin
                        bias_dac_q = bias_dac_q + 7'd1;
                        refresh    = 1'b1;
                    end
                end
            end else begin
                bias_dac_q = bias_preset_q;
            end
            if (fe_q[FE_MOD_TABLE])
                mod_dac_q = mod_from_curve(hi ? coeff_high_q : coeff_low_q,
                                           b.chip_temperature);
            else
                mod_dac_q = mod_preset_q;
        end
        if (bias_dac_q != prev_bias)
            bwr = 1'b1;
        if (mod_dac_q != prev_mod)
            mwr = 1'b1;
        r.laser_disable   = !laser_on;
        r.transmitter_on  = tx_on;
        r.bias_code       = bias_dac_q;
        r.bias_write      = bwr;
        r.mod_code        = mod_dac_q;
        r.mod_write       = mwr;
        r.refresh_request = refresh;
        return r;
    endfunction

    function automatic out_beat_t result_of(bit ld, bit tx, logic [6:0] bias, bit bw,
                                            logic [7:0] modc, bit mw, bit refresh);
        out_beat_t r;
        r.laser_disable   = ld;
        r.transmitter_on  = tx;
        r.bias_code       = bias;
        r.bias_write      = bw;
        r.mod_code        = modc;
        r.mod_write       = mw;
        r.refresh_request = refresh;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [2:0] idx, logic [31:0] value);
        stim_row_t r;
        r.kind         = ROW_CFG;
        r.reg_index    = idx;
        r.reg_value    = value;
        r.beat         = '0;
        r.hi_range     = 1'b0;
        r.typed        = 1'b0;
        r.typed_result = '0;
        return r;
    endfunction

    function automatic stim_row_t beat_row(bit sw_dis, bit pin, bit fault,
                                           logic [15:0] ibias, logic [15:0] power,
                                           logic [15:0] temp, bit hi);
        stim_row_t r;
        r.kind                  = ROW_BEAT;
        r.reg_index             = '0;
        r.reg_value             = '0;
        r.beat.soft_tx_disable  = sw_dis;
        r.beat.tx_disable_pin   = pin;
        r.beat.laser_fault      = fault;
        r.beat.bias_reading     = ibias;
        r.beat.power_reading    = power;
        r.beat.chip_temperature = temp;
        r.hi_range              = hi;
        r.typed                 = 1'b0;
        r.typed_result          = '0;
        return r;
    endfunction

    function automatic stim_row_t with_result(stim_row_t r, out_beat_t want);
        r.typed        = 1'b1;
        r.typed_result = want;
        return r;
    endfunction

    // random beat, power reading mostly near the band, bias reading often near the current limit
    function automatic stim_row_t random_row();
        logic [15:0] ibias;
        logic [15:0] power;
        logic [2:0]  pins;
        int unsigned near;
        int unsigned lim;
        lim = 500 * limit_q;
        if ($urandom_range(0, 9) < 6) begin
            near  = target_q * $urandom_range(90, 110) / 100;
            power = (near > 65535) ? 16'hFFFF : near[15:0];
        end else begin
            power = 16'($urandom);
        end
        if ($urandom_range(0, 1) == 1) begin
            near  = lim + $urandom_range(0, 8);
            near  = (near < 4) ? 0 : near - 4;
            ibias = (near > 65535) ? 16'hFFFF : near[15:0];
        end else begin
            ibias = 16'($urandom);
        end
        // most ticks have the transmitter enabled
        pins = ($urandom_range(0, 99) < 85) ? 3'b000 : 3'($urandom);
        return beat_row(pins[0], pins[1], pins[2], ibias, power, 16'($urandom),
                        1'($urandom_range(0, 1)));
    endfunction

    function automatic logic [31:0] random_coeff();
        int slope;
        int offset;
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        // gentle slope so the modulation code sweeps the range instead of clipping
        slope  = int'($urandom_range(0, 1024)) - 512;
        offset = int'($urandom_range(0, 400)) - 100;
        return {slope[15:0], offset[15:0]};
    endfunction

    function automatic int draw_wait();
        return calm ? 0 : int'($urandom_range(0, 4));
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    task automatic check_result(out_beat_t got);
        out_beat_t want;
        if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: result beat with nothing expected, expected none got %h",
                     $time, got);
        end else begin
            want = pending_results.pop_front();
            check_field("laser_disable", 8'(want.laser_disable), 8'(got.laser_disable));
            check_field("transmitter_on", 8'(want.transmitter_on),
                        8'(got.transmitter_on));
            check_field("bias_code", 8'(want.bias_code), 8'(got.bias_code));
            check_field("bias_write", 8'(want.bias_write), 8'(got.bias_write));
            check_field("mod_code", want.mod_code, got.mod_code);
            check_field("mod_write", 8'(want.mod_write), 8'(got.mod_write));
            check_field("refresh_request", 8'(want.refresh_request),
                        8'(got.refresh_request));
        end
    endtask

    // result side: check every beat taken, then hold tready low for a random stall
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(out_beat_t'(m_tdata[$bits(out_beat_t)-1:0]));
                ready_wait = draw_wait();
            end
            if (ready_wait > 0) begin
                m_tready <= 1'b0;
                ready_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // lower tvalid once, only if the last beat left it high
    task automatic drop_valid();
        if (s_valid_held) begin
            s_tvalid <= 1'b0;
            s_valid_held = 1'b0;
        end
    endtask

    // every beat gives one result, so an empty queue means the core is idle
    task automatic wait_idle();
        drop_valid();
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        wait_idle();
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FEATURE_ENABLES: fe_q          = value[2:0];
            REG_POWER_TARGET:    target_q      = value[15:0];
            REG_BIAS_LIMIT_MA:   limit_q       = value[7:0];
            REG_BIAS_PRESET:     bias_preset_q = value[6:0];
            REG_MOD_PRESET:      mod_preset_q  = value[7:0];
            REG_MOD_COEFF_LOW:   coeff_low_q   = value;
            REG_MOD_COEFF_HIGH:  coeff_high_q  = value;
            default: ;
        endcase
    endtask

    // input side: random gap, then hold the beat until it is taken
    task automatic send_item(stim_row_t r);
        int        gap;
        out_beat_t predicted;
        gap = draw_wait();
        if (gap > 0) begin
            drop_valid();
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(r.beat);
        s_tuser  <= r.hi_range;
        s_valid_held = 1'b1;
        do
            @(posedge aclk);
        while (!s_tready);
        predicted = step_laser_loop(r.beat, r.hi_range);
        pending_results.push_back(r.typed ? r.typed_result : predicted);
    endtask

    task automatic program_random();
        logic [15:0] target;
        case ($urandom_range(0, 5))
            0:       target = 16'h0000;
            1:       target = 16'hFFFF;
            default: target = 16'($urandom_range(50, 60000));
        endcase
        write_reg(REG_FEATURE_ENABLES, $urandom_range(0, 7));
        write_reg(REG_POWER_TARGET, {16'd0, target});
        write_reg(REG_BIAS_LIMIT_MA, $urandom_range(0, 255));
        write_reg(REG_BIAS_PRESET, $urandom_range(0, 127));
        write_reg(REG_MOD_PRESET, $urandom_range(0, 255));
        write_reg(REG_MOD_COEFF_LOW, random_coeff());
        write_reg(REG_MOD_COEFF_HIGH, random_coeff());
    endtask

    initial begin
        stim_row_t rows[$];
        int        phase;
        int        k;

        // registers still at reset: first tick loads zero presets, strobes all
        rows.push_back(with_result(beat_row(0, 0, 0, 16'd0, 16'd0, 16'd0, 0),
                                   result_of(0, 1, 7'd0, 1, 8'd0, 1, 1)));
        // software disable, then disable pin, then fault: codes held, no strobes
        rows.push_back(with_result(beat_row(1, 0, 0, 16'd0, 16'd0, 16'd0, 0),
                                   result_of(1, 0, 7'd0, 0, 8'd0, 0, 0)));
        rows.push_back(with_result(beat_row(0, 1, 0, 16'd0, 16'd0, 16'd0, 0),
                                   result_of(1, 0, 7'd0, 0, 8'd0, 0, 0)));
        rows.push_back(with_result(beat_row(0, 0, 1, 16'd0, 16'd0, 16'd0, 0),
                                   result_of(0, 0, 7'd0, 0, 8'd0, 0, 0)));
        // power control off: codes jump to the top presets
        rows.push_back(cfg_row(REG_BIAS_PRESET, 32'd127));
        rows.push_back(cfg_row(REG_MOD_PRESET, 32'd255));
        rows.push_back(with_result(beat_row(0, 0, 0, 16'd0, 16'd0, 16'd0, 0),
                                   result_of(0, 1, 7'd127, 1, 8'd255, 1, 0)));
        // power control, widest target; code already at the top
        rows.push_back(cfg_row(REG_FEATURE_ENABLES, 32'(1 << FE_POWER_CTRL)));
        rows.push_back(cfg_row(REG_POWER_TARGET, 32'hFFFF));
        rows.push_back(beat_row(0, 0, 0, 16'd0, 16'hFFFF, 16'h7FFF, 0));
        rows.push_back(beat_row(0, 0, 0, 16'd0, 16'd0, 16'h8000, 1));
        // band edges around a target of 1000
        rows.push_back(cfg_row(REG_POWER_TARGET, 32'd1000));
        rows.push_back(beat_row(0, 0, 0, 16'd0, 16'd1030, 16'd0, 0));
        rows.push_back(beat_row(0, 0, 0, 16'd0, 16'd1031, 16'd0, 0));
        rows.push_back(beat_row(0, 0, 0, 16'd0, 16'd970, 16'd0, 0));
        rows.push_back(beat_row(0, 0, 0, 16'd0, 16'd969, 16'd0, 0));
        // zero current limit: any nonzero reading trips it, none lets the code rise
        rows.push_back(cfg_row(REG_FEATURE_ENABLES,
                               32'((1 << FE_POWER_CTRL) | (1 << FE_BIAS_LIMIT))));
        rows.push_back(cfg_row(REG_BIAS_LIMIT_MA, 32'd0));
        rows.push_back(beat_row(0, 0, 0, 16'hFFFF, 16'd1000, 16'd0, 0));
        rows.push_back(beat_row(0, 0, 0, 16'd0, 16'd0, 16'd0, 0));
        // widest limit never trips
        rows.push_back(cfg_row(REG_BIAS_LIMIT_MA, 32'd255));
        rows.push_back(beat_row(0, 0, 0, 16'hFFFF, 16'd0, 16'd0, 0));
        // bias code at zero: limit step and above-band step both stop there
        rows.push_back(cfg_row(REG_FEATURE_ENABLES, 32'd0));
        rows.push_back(cfg_row(REG_BIAS_PRESET, 32'd0));
        rows.push_back(beat_row(0, 0, 0, 16'd0, 16'd0, 16'd0, 0));
        rows.push_back(cfg_row(REG_FEATURE_ENABLES,
                               32'((1 << FE_POWER_CTRL) | (1 << FE_BIAS_LIMIT))));
        rows.push_back(cfg_row(REG_BIAS_LIMIT_MA, 32'd0));
        rows.push_back(beat_row(0, 0, 0, 16'd1, 16'hFFFF, 16'd0, 0));
        rows.push_back(cfg_row(REG_FEATURE_ENABLES, 32'(1 << FE_POWER_CTRL)));
        rows.push_back(beat_row(0, 0, 0, 16'd0, 16'hFFFF, 16'd0, 0));
        // temperature table, both ranges, both temperature extremes
        rows.push_back(cfg_row(REG_FEATURE_ENABLES, 32'(1 << FE_MOD_TABLE)));
        rows.push_back(cfg_row(REG_MOD_PRESET, 32'd0));
        rows.push_back(cfg_row(REG_MOD_COEFF_LOW, 32'h0100_0000));
        rows.push_back(cfg_row(REG_MOD_COEFF_HIGH, 32'h7FFF_7FFF));
        rows.push_back(beat_row(0, 0, 0, 16'd0, 16'd0, 16'h7FFF, 0));
        rows.push_back(beat_row(0, 0, 0, 16'd0, 16'd0, 16'h8000, 0));
        rows.push_back(beat_row(0, 0, 0, 16'd0, 16'd0, 16'h7FFF, 1));
        rows.push_back(beat_row(0, 0, 0, 16'd0, 16'd0, 16'h8000, 1));
        rows.push_back(cfg_row(REG_MOD_COEFF_HIGH, 32'h8000_8000));
        rows.push_back(beat_row(0, 0, 0, 16'd0, 16'd0, 16'h8000, 1));
        rows.push_back(beat_row(0, 0, 0, 16'd0, 16'd0, 16'h7FFF, 1));
        // transmitter off with the table on: codes hold
        rows.push_back(beat_row(0, 0, 1, 16'd0, 16'd0, 16'h1234, 0));
        // every feature on, widest register values
        rows.push_back(cfg_row(REG_FEATURE_ENABLES, 32'd7));
        rows.push_back(cfg_row(REG_POWER_TARGET, 32'hFFFF));
        rows.push_back(cfg_row(REG_BIAS_LIMIT_MA, 32'd255));
        rows.push_back(cfg_row(REG_MOD_COEFF_LOW, 32'hFFFF_FFFF));
        rows.push_back(beat_row(0, 0, 0, 16'd0, 16'd0, 16'h0100, 0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG)
                write_reg(rows[i].reg_index, rows[i].reg_value);
            else
                send_item(rows[i]);
        end

        // random phases, each under a fresh register setting
        for (phase = 0; phase < RUN_PHASES; phase++) begin
            program_random();
            calm = ($urandom_range(0, 3) == 0);
            for (k = 0; k < PHASE_BEATS; k++) begin
                // now and then let the pipeline run dry
                if ($urandom_range(0, 149) == 0)
                    wait_idle();
                send_item(random_row());
            end
        end
        calm = 1'b0;

        // drain, then watch for stray beats
        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("laser_bias_mod_control_core: match");
        else
            $display("laser_bias_mod_control_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl
rtl/lbmc_pkg.sv
rtl/laser_bias_mod_control_core.sv
test/tb_laser_bias_mod_control_core.sv
